// ----- hw/rtl/cubic_curve_point_sampler_assert.svh -----
// assertion macros for the cubic curve point sampler
`ifndef CUBIC_CURVE_POINT_SAMPLER_ASSERT_SVH
`define CUBIC_CURVE_POINT_SAMPLER_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define CCPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccps assertion failed");

// next-cycle implication, checked on clk, off during rst
`define CCPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccps assertion failed");

`endif

// ----- hw/rtl/ccps_pkg.sv -----
// shared constants, codes and types of the cubic curve point sampler
package ccps_pkg;

  localparam int COORD_W    = 16;
  localparam int CNT_W      = 7;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // sample parameter in unsigned q1.16
  localparam int T_W = 17;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << (T_W - 1);
  localparam int STEP_W = $clog2(T_W);

  // datapath widths
  localparam int COEF_W     = 21;
  localparam int OPND_W     = 33;
  localparam int PROD_W     = OPND_W + T_W + 1;
  localparam int ACC_W      = 72;
  localparam int FRAC_SHIFT = 48;
  localparam int SPLIT_U    = 16;
  localparam int SPLIT_I    = 32;

  // multiplier operand select
  localparam logic [2:0] MUL_COEF     = 3'd0;
  localparam logic [2:0] MUL_ACC_LO16 = 3'd1;
  localparam logic [2:0] MUL_SRC_HI16 = 3'd2;
  localparam logic [2:0] MUL_ACC_LO32 = 3'd3;
  localparam logic [2:0] MUL_SRC_HI32 = 3'd4;

  // accumulator addend select
  localparam logic [1:0] ADD_PROD0  = 2'd0;
  localparam logic [1:0] ADD_PROD16 = 2'd1;
  localparam logic [1:0] ADD_PROD32 = 2'd2;
  localparam logic [1:0] ADD_BIAS   = 2'd3;

  typedef struct packed {
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       snap;
    logic       acc_en;
    logic       keep;
    logic [1:0] add_sel;
  } mac_ctl_t;

endpackage

// ----- hw/rtl/ccps_if.sv -----
// request and point channel interfaces of the cubic curve point sampler
interface ccps_req_if import ccps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] middle_x;
  logic signed [COORD_W-1:0] middle_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic        [CNT_W-1:0]   point_count;

  modport source (
    output valid, start_x, start_y, middle_x, middle_y, end_x, end_y, point_count,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, middle_x, middle_y, end_x, end_y, point_count,
    output ready
  );
endinterface

interface ccps_pt_if import ccps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;

  modport source (
    output valid, point_x, point_y, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, last_point,
    output ready
  );
endinterface

// ----- hw/rtl/ccps_div.sv -----
// restoring divider: one quotient bit per cycle of 1.0 (q1.16) by the step count
module ccps_div import ccps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] divisor,
  output logic             done,
  output logic [T_W-1:0]   quot,
  output logic [IDX_W-1:0] rem
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [T_W-1:0]    dvd;
  logic [IDX_W-1:0]  dsr;
  logic [IDX_W:0]    rem_w;
  logic              fit;
  logic [IDX_W-1:0]  rem_next;

  always_comb begin
    rem_w    = {rem, dvd[T_W-1]};
    fit      = rem_w >= {1'b0, dsr};
    rem_next = fit ? IDX_W'(rem_w - {1'b0, dsr}) : IDX_W'(rem_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(T_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= T_ONE;
      dsr  <= divisor;
      quot <= '0;
      rem  <= '0;
    end else if (busy) begin
      dvd  <= dvd << 1;
      quot <= {quot[T_W-2:0], fit};
      rem  <= rem_next;
    end
  end

endmodule

// ----- hw/rtl/ccps_mac.sv -----
// shared multiply-accumulate unit: 33x18 signed multiplier and 72-bit accumulator
module ccps_mac import ccps_pkg::*; (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [ACC_W-1:0]  base,
  input  logic        [T_W-1:0]    t,
  output logic signed [ACC_W-1:0]  acc
);

  localparam logic [ACC_W-1:0] RND_BIAS = (ACC_W'(1) << FRAC_SHIFT) - ACC_W'(1);

  logic signed [OPND_W-1:0] opnd;
  logic signed [T_W:0]      t_s;
  logic signed [PROD_W-1:0] mul_res;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  src;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_next;

  // operand select, chunks of a wide value go in low part first
  always_comb begin
    case (ctl.mul_sel)
      MUL_COEF:     opnd = OPND_W'(coef);
      MUL_ACC_LO16: opnd = $signed({{(OPND_W-SPLIT_U){1'b0}}, acc[SPLIT_U-1:0]});
      MUL_SRC_HI16: opnd = src[SPLIT_U +: OPND_W];
      MUL_ACC_LO32: opnd = $signed({{(OPND_W-SPLIT_I){1'b0}}, acc[SPLIT_I-1:0]});
      MUL_SRC_HI32: opnd = src[SPLIT_I +: OPND_W];
      default:      opnd = '0;
    endcase
  end

  assign t_s     = $signed({1'b0, t});
  assign mul_res = opnd * t_s;

  always_comb begin
    case (ctl.add_sel)
      ADD_PROD0:  addend = ACC_W'(prod);
      ADD_PROD16: addend = ACC_W'(prod) <<< SPLIT_U;
      ADD_PROD32: addend = ACC_W'(prod) <<< SPLIT_I;
      ADD_BIAS:   addend = acc[ACC_W-1] ? $signed(RND_BIAS) : '0;
      default:    addend = '0;
    endcase
    acc_next = (ctl.keep ? acc : base) + addend;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= mul_res;
    end
    if (ctl.snap) begin
      src <= acc;
    end
    if (ctl.acc_en) begin
      acc <= acc_next;
    end
  end

endmodule

// ----- hw/rtl/cubic_curve_point_sampler.sv -----
// cubic curve point sampler top level. A request carries three control points (start,
// middle, end) and a point count n; counts below 2 act as 2 and counts above 64 as 64.
// The block forms the power-basis coefficients c = 3(middle-start), b = 3(end-middle)-c,
// a = end-start-c-b for each axis and emits n points in order, the last one flagged.
// Point i is taken at t = floor(i*65536/(n-1)) in q1.16, so the first point is the
// start and the last is exactly t = 1.0; each coordinate is a*t^3+b*t^2+c*t, truncated
// toward zero, plus the start coordinate, saturated to 16-bit signed. The block takes one
// request at a time; req.ready is high only while idle. After acceptance a bit-serial
// divider forms 65536/(n-1), the step is handed over, and then each point takes ten
// steps per axis through the single shared 33x18 multiplier and 72-bit accumulator,
// plus an emit step that hands the point to the output register and waits while that
// register still holds a point the sink has not taken. The output register lets the
// next point be worked on while one waits.
`include "cubic_curve_point_sampler_assert.svh"

module cubic_curve_point_sampler import ccps_pkg::*; (
  input  logic clk,
  input  logic rst,
  ccps_req_if.sink  req,
  ccps_pt_if.source pt
);

  localparam int SUM_W = COORD_W + 9;
  localparam int Q_W   = ACC_W - FRAC_SHIFT;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2**(COORD_W-1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV    = 4'd1;
  localparam logic [3:0] ST_MUL_A  = 4'd2;
  localparam logic [3:0] ST_ADD_B  = 4'd3;
  localparam logic [3:0] ST_MUL_UL = 4'd4;
  localparam logic [3:0] ST_MUL_UH = 4'd5;
  localparam logic [3:0] ST_ADD_UH = 4'd6;
  localparam logic [3:0] ST_MUL_IL = 4'd7;
  localparam logic [3:0] ST_MUL_IH = 4'd8;
  localparam logic [3:0] ST_ADD_IH = 4'd9;
  localparam logic [3:0] ST_BIAS   = 4'd10;
  localparam logic [3:0] ST_SAT    = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_t;

  // power-basis coefficients from the three control points of one axis
  function automatic coef_t make_coef(input logic signed [COORD_W-1:0] p1,
                                      input logic signed [COORD_W-1:0] p2,
                                      input logic signed [COORD_W-1:0] p3);
    logic signed [COORD_W:0]   d1;
    logic signed [COORD_W:0]   d2;
    logic signed [COEF_W-1:0]  w1;
    logic signed [COEF_W-1:0]  w2;
    logic signed [COEF_W-1:0]  wd;
    coef_t                     r;
    d1  = (COORD_W+1)'(p2) - (COORD_W+1)'(p1);
    d2  = (COORD_W+1)'(p3) - (COORD_W+1)'(p2);
    w1  = COEF_W'(d1);
    w2  = COEF_W'(d2);
    wd  = w2 - w1;
    r.c = (w1 <<< 1) + w1;
    r.b = (wd <<< 1) + wd;
    r.a = w1 - (w2 <<< 1);
    return r;
  endfunction

  logic [3:0]               state;
  logic                     coord;
  logic [IDX_W-1:0]         pidx;
  logic [IDX_W-1:0]         d;
  logic [T_W-1:0]           q0;
  logic [IDX_W-1:0]         r0;
  logic [T_W-1:0]           t;
  logic [IDX_W-1:0]         r;
  coef_t                    cf_x;
  coef_t                    cf_y;
  logic signed [COORD_W-1:0] p1_x;
  logic signed [COORD_W-1:0] p1_y;
  logic signed [COORD_W-1:0] px;

  // output register
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      out_last;

  logic             in_acc;
  logic [IDX_W-1:0] d_in;
  logic             div_done;
  logic [T_W-1:0]   div_quot;
  logic [IDX_W-1:0] div_rem;

  mac_ctl_t                  ctl;
  coef_t                     cf_sel;
  logic signed [COEF_W-1:0]  coef;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   acc;

  logic signed [Q_W-1:0]     q_int;
  logic signed [SUM_W-1:0]   sum;
  logic signed [COORD_W-1:0] sat_val;
  logic signed [COORD_W-1:0] p1_sel;

  logic             emit_ok;
  logic             last_now;
  logic [IDX_W:0]   r_sum;
  logic             wrap;
  logic [T_W-1:0]   t_next;
  logic [IDX_W-1:0] r_next;

  assign in_acc    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // steps between points: n clamped to 2..MAX_POINTS, d = n-1
  always_comb begin
    if (req.point_count < CNT_W'(2)) begin
      d_in = IDX_W'(1);
    end else if (req.point_count > CNT_W'(MAX_POINTS)) begin
      d_in = IDX_W'(MAX_POINTS - 1);
    end else begin
      d_in = IDX_W'(req.point_count - CNT_W'(1));
    end
  end

  ccps_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (in_acc),
    .divisor (d_in),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // per-axis operand selection
  assign cf_sel = coord ? cf_y : cf_x;
  assign p1_sel = coord ? p1_y : p1_x;
  assign coef   = cf_sel.a;

  // micro-program: u = a*t + b<<16, inner = u*t + c<<32, val = inner*t >> 48
  always_comb begin
    ctl  = '0;
    base = '0;
    case (state)
      ST_MUL_A: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_COEF;
      end
      ST_ADD_B: begin
        ctl.acc_en  = 1'b1;
        ctl.add_sel = ADD_PROD0;
        base        = ACC_W'(cf_sel.b) <<< SPLIT_U;
      end
      ST_MUL_UL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_ACC_LO16;
        ctl.snap    = 1'b1;
      end
      ST_MUL_UH: begin
        ctl.acc_en  = 1'b1;
        ctl.add_sel = ADD_PROD0;
        base        = ACC_W'(cf_sel.c) <<< SPLIT_I;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_SRC_HI16;
      end
      ST_ADD_UH: begin
        ctl.acc_en  = 1'b1;
        ctl.keep    = 1'b1;
        ctl.add_sel = ADD_PROD16;
      end
      ST_MUL_IL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_ACC_LO32;
        ctl.snap    = 1'b1;
      end
      ST_MUL_IH: begin
        ctl.acc_en  = 1'b1;
        ctl.add_sel = ADD_PROD0;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_SRC_HI32;
      end
      ST_ADD_IH: begin
        ctl.acc_en  = 1'b1;
        ctl.keep    = 1'b1;
        ctl.add_sel = ADD_PROD32;
      end
      ST_BIAS: begin
        // rounds a negative product toward zero before the shift
        ctl.acc_en  = 1'b1;
        ctl.keep    = 1'b1;
        ctl.add_sel = ADD_BIAS;
      end
      default: begin
        ctl  = '0;
        base = '0;
      end
    endcase
  end

  ccps_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .coef (coef),
    .base (base),
    .t    (t),
    .acc  (acc)
  );

  // integer part plus start coordinate, clamped to the coordinate range
  always_comb begin
    q_int = acc[ACC_W-1:FRAC_SHIFT];
    sum   = SUM_W'(q_int) + SUM_W'(p1_sel);
    if (sum > SAT_HI) begin
      sat_val = SAT_HI[COORD_W-1:0];
    end else if (sum < SAT_LO) begin
      sat_val = SAT_LO[COORD_W-1:0];
    end else begin
      sat_val = sum[COORD_W-1:0];
    end
  end

  // next t: add the whole step, carry the fractional remainder
  always_comb begin
    r_sum  = {1'b0, r} + {1'b0, r0};
    wrap   = r_sum >= {1'b0, d};
    t_next = t + q0 + T_W'(wrap);
    r_next = wrap ? IDX_W'(r_sum - {1'b0, d}) : IDX_W'(r_sum);
  end

  assign emit_ok  = !out_valid || pt.ready;
  assign last_now = (pidx == d);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      coord <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_DIV;
            coord <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_MUL_A;
          end
        end
        ST_MUL_A:  state <= ST_ADD_B;
        ST_ADD_B:  state <= ST_MUL_UL;
        ST_MUL_UL: state <= ST_MUL_UH;
        ST_MUL_UH: state <= ST_ADD_UH;
        ST_ADD_UH: state <= ST_MUL_IL;
        ST_MUL_IL: state <= ST_MUL_IH;
        ST_MUL_IH: state <= ST_ADD_IH;
        ST_ADD_IH: state <= ST_BIAS;
        ST_BIAS:   state <= ST_SAT;
        ST_SAT: begin
          if (!coord) begin
            coord <= 1'b1;
            state <= ST_MUL_A;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            coord <= 1'b0;
            state <= last_now ? ST_IDLE : ST_MUL_A;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // request payload, divider results and per-point walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cf_x <= make_coef(req.start_x, req.middle_x, req.end_x);
      cf_y <= make_coef(req.start_y, req.middle_y, req.end_y);
      p1_x <= req.start_x;
      p1_y <= req.start_y;
      d    <= d_in;
      t    <= '0;
      r    <= '0;
      pidx <= '0;
    end
    if (state == ST_DIV && div_done) begin
      q0 <= div_quot;
      r0 <= div_rem;
    end
    if (state == ST_SAT && !coord) begin
      px <= sat_val;
    end
    if (state == ST_EMIT && emit_ok && !last_now) begin
      t    <= t_next;
      r    <= r_next;
      pidx <= pidx + IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && emit_ok) begin
      out_valid <= 1'b1;
    end else if (pt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_ok) begin
      out_x    <= px;
      out_y    <= sat_val;
      out_last <= last_now;
    end
  end

  assign pt.valid      = out_valid;
  assign pt.point_x    = out_x;
  assign pt.point_y    = out_y;
  assign pt.last_point = out_last;

  // divider finishes only while the sequencer waits for it
  `CCPS_ASSERT_IMPL(a_div_done_in_div, div_done, state == ST_DIV)
  // the incremental step never runs past 1.0
  `CCPS_ASSERT_IMPL(a_t_in_range, state != ST_IDLE, t <= T_ONE)
  // carried remainder stays below the step count
  `CCPS_ASSERT_IMPL(a_rem_below_d, state != ST_IDLE, r < d)
  // the final point lands exactly on t = 1.0
  `CCPS_ASSERT_IMPL(a_last_at_one, state == ST_EMIT && last_now, t == T_ONE)
  // handing over the last point ends the request with a flagged output
  `CCPS_ASSERT_NEXT(a_last_ends, state == ST_EMIT && emit_ok && last_now,
                    state == ST_IDLE && out_valid && out_last)

endmodule

// ----- verif/cubic_curve_point_sampler_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the cubic curve point sampler: directed and random curves
module cubic_curve_point_sampler_test;
  import ccps_pkg::*;

  // random curves after the directed ones
  localparam int NUM_RANDOM   = 364;
  // accepted requests per idling phase: sender 32 / receiver 49, swapped, then none
  localparam int PHASE_LEN    = 127;
  // the long receiver hold-off starts once this many requests went in
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 800;
  // stall limit above both a 64 point curve and the receiver hold-off
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 1400;
  localparam longint T_SCALE  = 65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic        [CNT_W-1:0]   count;
  } curve_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ccps_req_if req_ch ();
  ccps_pt_if  pt_ch ();

  cubic_curve_point_sampler dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pt  (pt_ch)
  );

  always #10 clk = ~clk;

  curve_req_t   pending_curves[$];   // requests not yet offered
  curve_point_t expected_points[$];  // predicted points, oldest first
  curve_req_t   offered_curve;       // request currently on the channel
  int           reqs_accepted = 0;
  int           mismatches = 0;
  int           hold_left;
  logic         hold_taken;
  int           quiet_cycles = 0;

  // idle chance in percent for the current phase, on the sender or the receiver side
  function automatic int idle_pct(bit receiver);
    if (reqs_accepted < PHASE_LEN) begin
      return receiver ? 49 : 32;
    end else if (reqs_accepted < 2 * PHASE_LEN) begin
      return receiver ? 32 : 49;
    end
    return 0;
  endfunction

  // one coordinate at q1.16 parameter t: exact polynomial, truncated toward zero,
  // shifted by the start coordinate and clamped to 16-bit signed
  function automatic logic signed [COORD_W-1:0] curve_coord(longint p1, longint p2,
                                                             longint p3, longint t);
    longint     c, b, a, poly, mag, v;
    logic [127:0] prod;
    c = 3 * (p2 - p1);
    b = 3 * (p3 - p2) - c;
    a = p3 - p1 - c - b;
    // scaled by 2^48 once multiplied by t
    poly = a * (t * t) + b * t * T_SCALE + c * 64'sh1_0000_0000;
    mag = (poly < 0) ? -poly : poly;
    prod = 128'(mag) * 128'(t);
    v = longint'(prod >> FRAC_SHIFT);
    if (poly < 0) begin
      v = -v;
    end
    v = v + p1;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return COORD_W'(v);
  endfunction

  // push every point that one accepted request must produce
  function automatic void queue_curve_points(curve_req_t c);
    int           n;
    longint       t;
    curve_point_t p;
    n = c.count;
    // counts below 2 act as 2, above the maximum as the maximum
    if (n < 2) begin
      n = 2;
    end
    if (n > MAX_POINTS) begin
      n = MAX_POINTS;
    end
    for (int i = 0; i < n; i++) begin
      t = (longint'(i) * T_SCALE) / (n - 1);
      p.x = curve_coord(c.sx, c.mx, c.ex, t);
      p.y = curve_coord(c.sy, c.my, c.ey, t);
      p.last = (i == n - 1);
      expected_points.push_back(p);
    end
  endfunction

  function automatic void add_curve(int sx, int sy, int mx, int my, int ex, int ey,
                                    int count);
    curve_req_t c;
    c.sx = COORD_W'(sx);
    c.sy = COORD_W'(sy);
    c.mx = COORD_W'(mx);
    c.my = COORD_W'(my);
    c.ex = COORD_W'(ex);
    c.ey = COORD_W'(ey);
    c.count = CNT_W'(count);
    pending_curves.push_back(c);
  endfunction

  // mostly full random, with a share of extremes and small values near zero
  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15));
      3: return -16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  // most curves short so the run stays fast, some long, some past the maximum
  function automatic logic [CNT_W-1:0] random_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return CNT_W'($urandom_range(0, 12));
    end else if (r < 90) begin
      return CNT_W'($urandom_range(13, 127));
    end
    return CNT_W'($urandom_range(MAX_POINTS, 127));
  endfunction

  // request driver: predicts on acceptance, then offers the next request or idles
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        queue_curve_points(offered_curve);
        reqs_accepted <= reqs_accepted + 1;
      end
      // valid stays up until the request is taken
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_curves.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          offered_curve = pending_curves.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.start_x     <= offered_curve.sx;
          req_ch.start_y     <= offered_curve.sy;
          req_ch.middle_x    <= offered_curve.mx;
          req_ch.middle_y    <= offered_curve.my;
          req_ch.end_x       <= offered_curve.ex;
          req_ch.end_y       <= offered_curve.ey;
          req_ch.point_count <= offered_curve.count;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // point monitor: compares each accepted point with the oldest prediction,
  // then picks ready for the next cycle
  always @(posedge clk) begin
    curve_point_t got, want;
    if (rst) begin
      pt_ch.ready <= 1'b0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else begin
      if (pt_ch.valid && pt_ch.ready) begin
        got = '{pt_ch.point_x, pt_ch.point_y, pt_ch.last_point};
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d last=%0d",
                   $time, got.x, got.y, got.last);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            $display("%0t: expected x=%0d y=%0d last=%0d, actual x=%0d y=%0d last=%0d",
                     $time, want.x, want.y, want.last, got.x, got.y, got.last);
            mismatches++;
          end
        end
      end
      // one long hold-off: the block fills its output register and stops taking
      // requests while the driver keeps offering
      if (hold_left != 0) begin
        pt_ch.ready <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (!hold_taken && reqs_accepted >= HOLD_AT) begin
        pt_ch.ready <= 1'b0;
        hold_left   <= HOLD_CYCLES;
        hold_taken  <= 1'b1;
      end else begin
        pt_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (pt_ch.valid && pt_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.start_x     = '0;
    req_ch.start_y     = '0;
    req_ch.middle_x    = '0;
    req_ch.middle_y    = '0;
    req_ch.end_x       = '0;
    req_ch.end_y       = '0;
    req_ch.point_count = '0;
    pt_ch.ready        = 1'b0;

    // small counts: zero and one act as two
    add_curve(0, 0, 0, 0, 0, 0, 0);
    add_curve(100, -200, 300, 400, -500, 600, 1);
    add_curve(100, -200, 300, 400, -500, 600, 2);
    add_curve(-32768, 32767, 32767, -32768, -32768, 32767, 3);
    // coordinate extremes, maximum count and counts past it
    add_curve(-32768, -32768, -32768, -32768, -32768, -32768, 64);
    add_curve(32767, 32767, 32767, 32767, 32767, 32767, 65);
    add_curve(-32768, -32768, 32767, 32767, 32767, 32767, 127);
    add_curve(32767, 32767, -32768, -32768, -32768, -32768, 64);
    add_curve(-32768, 32767, 32767, -32768, -32768, 32767, 5);
    add_curve(0, 0, 32767, -32768, -32768, 32767, 17);
    add_curve(-32768, 0, 0, -32768, 32767, 32767, 2);
    // small spans where truncation toward zero matters on both signs, then mixed large ones
    add_curve(-1, 1, 0, 0, 1, -1, 4);
    add_curve(7, -7, -3, 3, 2, -2, 9);
    add_curve(12345, -23456, -30000, 30000, 1, -1, 63);
    add_curve(1000, -1000, -20000, 20000, 30000, -30000, 33);
    add_curve(-5, 5, 32767, -32768, 5, -5, 100);
    for (int k = 0; k < NUM_RANDOM; k++) begin
      add_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                random_coord(), random_coord(), random_count());
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_curves.size() != 0 || req_ch.valid || expected_points.size() != 0) begin
      @(posedge clk);
    end
    // leave room for any stray point after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
